FILE: rtl/m3a_pkg.sv
// Shared types and constants for the 3x3 matrix ALU.
package m3a_pkg;

  // Matrix geometry and element width
  localparam int ELEM_WIDTH = 16;
  localparam int DIM        = 3;
  localparam int NELEM      = DIM * DIM;
  localparam int IDX_W      = $clog2(NELEM);
  localparam int CNT_W      = (DIM > 2) ? $clog2(DIM) : 1;

  // Fixed field widths of the stream items
  localparam int CMD_W       = 3;
  localparam int IN_IDX_W    = 4;
  localparam int VAL_W       = 16;
  localparam int SCALAR_W    = 16;
  localparam int RES_W       = 33;
  localparam int IN_TDATA_W  = 8 * ((IN_IDX_W + VAL_W + SCALAR_W + 7) / 8);
  localparam int OUT_TDATA_W = 8 * ((RES_W + IN_IDX_W + 7) / 8);

  // Multiplier operand widths (second operand is a B element or the scalar)
  localparam int OPB_W  = (ELEM_WIDTH > SCALAR_W) ? ELEM_WIDTH : SCALAR_W;
  localparam int PROD_W = ELEM_WIDTH + OPB_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_A = 3'd0,
    CMD_LOAD_B = 3'd1,
    CMD_MUL    = 3'd2,
    CMD_ADD    = 3'd3,
    CMD_SUB    = 3'd4,
    CMD_SCALE  = 3'd5
  } cmd_e;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } ctl_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic             load_a;
    logic             load_b;
    logic [IDX_W-1:0] wr_idx;
    logic             capture;
    logic             issue;
    cmd_e             op;
    logic [IDX_W-1:0] a_idx;
    logic [IDX_W-1:0] b_idx;
    logic             first;
    logic             last_term;
    logic [IDX_W-1:0] elem_idx;
    logic             last_elem;
  } dp_cmd_t;

endpackage

FILE: rtl/matrix3x3_alu.sv
// Load items write one A or B element and leave the block ready; the first result of a compute
//   item passes the state, term and output registers, multiply summing three terms per element.
// Add, subtract and scale: 9 results, one per cycle unless stalled; the next item is taken once
//   the sequencer is back in idle. Multiply: 27 multiply-accumulate steps on the single shared
//   multiplier, one result per three steps, next item again after idle. Stalls hold the pipeline.
// Reset: rst_ni async active low clears sequencer and valid flags; matrices load before use.
module matrix3x3_alu (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [m3a_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // elem_index[3:0], elem_value[19:4], scalar[35:20], zero pad
  input  logic [m3a_pkg::CMD_W-1:0]           s_axis_tuser,  // cmd[2:0]
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [m3a_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // result_value[32:0], result_index[36:33], zero pad
  output logic                                m_axis_tlast   // last
);
  import m3a_pkg::*;

  dp_cmd_t                 dp_cmd;
  logic                    advance;
  logic signed [RES_W-1:0] out_value;
  logic [IDX_W-1:0]        out_index;

  // Unpacked input fields
  logic [IN_IDX_W-1:0]        elem_index;
  logic signed [VAL_W-1:0]    elem_value;
  logic signed [SCALAR_W-1:0] scalar;

  assign elem_index = s_axis_tdata[IN_IDX_W-1:0];
  assign elem_value = s_axis_tdata[IN_IDX_W+VAL_W-1:IN_IDX_W];
  assign scalar     = s_axis_tdata[IN_IDX_W+VAL_W+SCALAR_W-1:IN_IDX_W+VAL_W];

  // Sequencer: accepts one item at a time, issues one term per cycle unless the output stalls
  m3a_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .cmd_i        (s_axis_tuser),
    .elem_index_i (elem_index),
    .advance_i    (advance),
    .dp_cmd_o     (dp_cmd)
  );

  // Datapath: operand registers, multiplier, accumulator, output register
  m3a_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .dp_cmd_i     (dp_cmd),
    .elem_value_i (elem_value),
    .scalar_i     (scalar),
    .advance_o    (advance),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_value_o  (out_value),
    .out_index_o  (out_index),
    .out_last_o   (m_axis_tlast)
  );

  // Pack result fields, index above value, zero filled to whole bytes
  assign m_axis_tdata = OUT_TDATA_W'({IN_IDX_W'(out_index), out_value});

endmodule

FILE: rtl/m3a_ctrl.sv
// Command sequencer: decodes input items and steps through element and term counters.
module m3a_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [m3a_pkg::CMD_W-1:0]      cmd_i,
  input  logic [m3a_pkg::IN_IDX_W-1:0]   elem_index_i,
  input  logic                           advance_i,
  output m3a_pkg::dp_cmd_t               dp_cmd_o
);
  import m3a_pkg::*;

  ctl_state_e       state_q, state_d;
  cmd_e             op_q, op_d;
  logic [CNT_W-1:0] row_q, row_d, col_q, col_d, t_q, t_d;
  logic [IDX_W-1:0] k_q, k_d;

  cmd_e cmd_in;
  logic in_accept, is_compute, is_mul, t_end, col_end, el_end, issue, idx_ok;

  assign cmd_in     = cmd_e'(cmd_i);
  assign in_accept  = in_valid_i && in_ready_o;
  assign is_compute = (cmd_in == CMD_MUL) || (cmd_in == CMD_ADD) ||
                      (cmd_in == CMD_SUB) || (cmd_in == CMD_SCALE);
  assign is_mul     = (op_q == CMD_MUL);
  assign t_end      = !is_mul || (t_q == CNT_W'(DIM - 1));
  assign col_end    = (col_q == CNT_W'(DIM - 1));
  assign el_end     = (k_q == IDX_W'(NELEM - 1));
  assign issue      = (state_q == ST_RUN) && advance_i;
  assign idx_ok     = {1'b0, elem_index_i} < (IN_IDX_W + 1)'(NELEM);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept && is_compute) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (issue && t_end && el_end) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Counters: term inner, then column, row
  always_comb begin
    op_d  = op_q;
    row_d = row_q;
    col_d = col_q;
    t_d   = t_q;
    k_d   = k_q;
    if (in_accept && is_compute) begin
      op_d  = cmd_in;
      row_d = '0;
      col_d = '0;
      t_d   = '0;
      k_d   = '0;
    end else if (issue) begin
      if (!t_end) begin
        t_d = t_q + CNT_W'(1);
      end else begin
        t_d = '0;
        k_d = k_q + IDX_W'(1);
        if (col_end) begin
          col_d = '0;
          row_d = row_q + CNT_W'(1);
        end else begin
          col_d = col_q + CNT_W'(1);
        end
      end
    end
  end

  // Outputs
  always_comb begin
    in_ready_o          = (state_q == ST_IDLE);
    dp_cmd_o.load_a     = in_accept && (cmd_in == CMD_LOAD_A) && idx_ok;
    dp_cmd_o.load_b     = in_accept && (cmd_in == CMD_LOAD_B) && idx_ok;
    dp_cmd_o.wr_idx     = elem_index_i[IDX_W-1:0];
    dp_cmd_o.capture    = in_accept && (cmd_in == CMD_SCALE);
    dp_cmd_o.issue      = issue;
    dp_cmd_o.op         = op_q;
    dp_cmd_o.a_idx      = is_mul ? IDX_W'(row_q * DIM + t_q) : k_q;
    dp_cmd_o.b_idx      = is_mul ? IDX_W'(t_q * DIM + col_q) : k_q;
    dp_cmd_o.first      = !is_mul || (t_q == '0);
    dp_cmd_o.last_term  = t_end;
    dp_cmd_o.elem_idx   = k_q;
    dp_cmd_o.last_elem  = el_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= CMD_MUL;
      row_q   <= '0;
      col_q   <= '0;
      t_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      row_q   <= row_d;
      col_q   <= col_d;
      t_q     <= t_d;
      k_q     <= k_d;
    end
  end

  // Final term of the final element ends the run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue && t_end && el_end |=> state_q == ST_IDLE)
    else $error("sequencer did not return to idle after last element");

  // A stalled run keeps its position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) && !advance_i |=> $stable(k_q) && $stable(t_q))
    else $error("counters moved during stall");

endmodule

FILE: rtl/m3a_dp.sv
// Datapath: A/B element registers, shared multiplier, accumulator and output register.
module m3a_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  m3a_pkg::dp_cmd_t                    dp_cmd_i,
  input  logic signed [m3a_pkg::VAL_W-1:0]    elem_value_i,
  input  logic signed [m3a_pkg::SCALAR_W-1:0] scalar_i,
  output logic                                advance_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [m3a_pkg::RES_W-1:0]    out_value_o,
  output logic [m3a_pkg::IDX_W-1:0]           out_index_o,
  output logic                                out_last_o
);
  import m3a_pkg::*;

  logic signed [ELEM_WIDTH-1:0] mat_a_q [NELEM];
  logic signed [ELEM_WIDTH-1:0] mat_b_q [NELEM];
  logic signed [SCALAR_W-1:0]   scalar_q;

  logic signed [ELEM_WIDTH-1:0] op_a, elem_b, wr_val;
  logic signed [OPB_W-1:0]      op_b;
  logic signed [PROD_W-1:0]     prod;
  logic signed [RES_W-1:0]      term_d, acc_sum;

  // Stage 1: term register
  logic                    p_v_q, p_first_q, p_last_q, p_lastel_q;
  logic signed [RES_W-1:0] p_term_q;
  logic [IDX_W-1:0]        p_idx_q;

  // Stage 2: accumulator and output register
  logic signed [RES_W-1:0] acc_q, out_value_q;
  logic                    out_v_q, out_last_q;
  logic [IDX_W-1:0]        out_idx_q;

  assign wr_val = ELEM_WIDTH'(elem_value_i);

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.load_a) mat_a_q[dp_cmd_i.wr_idx] <= wr_val;
    if (dp_cmd_i.load_b) mat_b_q[dp_cmd_i.wr_idx] <= wr_val;
    if (dp_cmd_i.capture) scalar_q <= scalar_i;
  end

  assign op_a   = mat_a_q[dp_cmd_i.a_idx];
  assign elem_b = mat_b_q[dp_cmd_i.b_idx];
  assign op_b   = (dp_cmd_i.op == CMD_SCALE) ? OPB_W'(scalar_q) : OPB_W'(elem_b);
  assign prod   = op_a * op_b;

  always_comb begin
    case (dp_cmd_i.op)
      CMD_ADD: term_d = RES_W'(op_a) + RES_W'(elem_b);
      CMD_SUB: term_d = RES_W'(op_a) - RES_W'(elem_b);
      default: term_d = RES_W'(prod);
    endcase
  end

  assign advance_o = !out_v_q || out_ready_i;
  assign acc_sum   = (p_first_q ? '0 : acc_q) + p_term_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else if (advance_o) begin
      p_v_q   <= dp_cmd_i.issue;
      out_v_q <= p_v_q && p_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && dp_cmd_i.issue) begin
      p_term_q   <= term_d;
      p_first_q  <= dp_cmd_i.first;
      p_last_q   <= dp_cmd_i.last_term;
      p_idx_q    <= dp_cmd_i.elem_idx;
      p_lastel_q <= dp_cmd_i.last_elem;
    end
    if (advance_o && p_v_q) begin
      if (p_last_q) begin
        out_value_q <= acc_sum;
        out_idx_q   <= p_idx_q;
        out_last_q  <= p_lastel_q;
      end else begin
        acc_q <= acc_sum;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign out_value_o = out_value_q;
  assign out_index_o = out_idx_q;
  assign out_last_o  = out_last_q;

  // Loads only happen while no term is being issued
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(dp_cmd_i.issue && (dp_cmd_i.load_a || dp_cmd_i.load_b)))
    else $error("matrix write during issue");

  // The marked result is always the last element position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_last_q |-> out_idx_q == IDX_W'(NELEM - 1))
    else $error("last flag on wrong element");

  // A pending term is not dropped under stall
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_v_q && !advance_o |=> p_v_q)
    else $error("term lost during stall");

endmodule
